// ===== rtl/core/chc_pkg.sv =====
// ============================================================================
// chc_pkg: shared types and constants of the canonical Huffman codec
// Transaction structs, function and result codes, write port types and the
// default table limits.
// ============================================================================
`default_nettype none

package chc_pkg;

   // Default table limits.
   localparam int MAX_CODE_LEN_DEF = 16;
   localparam int MAX_SYMBOLS_DEF  = 256;

   // Fixed field widths.
   localparam int SYM_W   = 8;
   localparam int CNT_W   = 8;
   localparam int CODE_W  = 16;
   localparam int LEN_W   = 5;
   localparam int LIDX_W  = 4;
   localparam int SYM_NUM = 256;

   // Request function codes.
   typedef enum logic [2:0] {
      FUNC_LOAD   = 3'd0,
      FUNC_APPEND = 3'd1,
      FUNC_DECODE = 3'd2,
      FUNC_ENCODE = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_SYMBOL = 2'd0,
      KIND_ERROR  = 2'd1,
      KIND_CODE   = 2'd2,
      KIND_MISS   = 2'd3
   } kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_RESP
   } state_type;

   // Request transaction payload.
   typedef struct packed {
      func_type          func;
      logic [LIDX_W-1:0] length_index;
      logic [CNT_W-1:0]  count;
      logic [SYM_W-1:0]  symbol;
      logic              bit_req;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      kind_type          kind;
      logic [SYM_W-1:0]  symbol_out;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  code_length;
   } rsp_type;

   // One entry of the per-symbol code store.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } code_entry_type;

   // Write port of the per-symbol code store.
   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
      code_entry_type   data;
   } code_wr_type;

endpackage

`default_nettype wire

// ===== rtl/core/canonical_huffman_codec.sv =====
// ============================================================================
// canonical_huffman_codec: canonical Huffman table with encode and decode
// Builds a JPEG style canonical code table from per-length counts and
// symbols, encodes symbols and decodes one coded bit per transaction.
// ============================================================================
//
// The req_ channel carries one command per transaction: load a length count,
// append a symbol, decode one bit, encode a symbol or clear the table. The
// rsp_ channel returns one result for an encode and for a decode bit that
// completes a symbol or runs to the maximum code length without a match.
// Commands are worked one at a time; req_stall is high while one is busy.
// A load, a clear and a decode bit that gives no result are done in the idle
// state without raising req_stall. A decode bit that gives a result, and an
// encode, pass through the response state, as the value or code store has a
// registered read port. An append enters each code length that it needs in
// turn in the append state, then places the symbol. Results land in an output
// register, so the next command is taken while a result waits; a further
// result waits in the sequencer until rsp_stall drops. Reset clears the tables
// at once; the stores need no clearing, as an entry is only used once written.
// ============================================================================
`default_nettype none

module canonical_huffman_codec #(
   parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF,
   parameter int MAX_SYMBOLS  = chc_pkg::MAX_SYMBOLS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire chc_pkg::req_type req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output chc_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_stall
);

   localparam int AW = $clog2(MAX_SYMBOLS);

   logic                      res_valid;
   chc_pkg::rsp_type          res_data;
   logic                      res_free;
   logic                      val_wr_en;
   logic [AW-1:0]             val_wr_addr;
   logic [chc_pkg::SYM_W-1:0] val_wr_data;
   logic                      val_rd_en;
   logic [AW-1:0]             val_rd_addr;
   logic [chc_pkg::SYM_W-1:0] val_rd_data;
   chc_pkg::code_wr_type      code_wr;
   logic                      code_rd_en;
   logic [chc_pkg::SYM_W-1:0] code_rd_addr;
   chc_pkg::code_entry_type   code_rd_data;

   logic             rsp_valid_ff;
   chc_pkg::rsp_type rsp_data_ff;

   // Sequencer with the length tables and decoder.
   chc_seq #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .MAX_SYMBOLS  (MAX_SYMBOLS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .res_free     (res_free),
      .val_wr_en    (val_wr_en),
      .val_wr_addr  (val_wr_addr),
      .val_wr_data  (val_wr_data),
      .val_rd_en    (val_rd_en),
      .val_rd_addr  (val_rd_addr),
      .val_rd_data  (val_rd_data),
      .code_wr      (code_wr),
      .code_rd_en   (code_rd_en),
      .code_rd_addr (code_rd_addr),
      .code_rd_data (code_rd_data)
   );

   // Symbol values in table order.
   chc_value_ram #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   // Codes and lengths by symbol.
   chc_code_ram u_code_ram (
      .clock   (clock),
      .wr      (code_wr),
      .rd_en   (code_rd_en),
      .rd_addr (code_rd_addr),
      .rd_data (code_rd_data)
   );

   // The output register takes a new result when empty or being drained.
   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chc_value_ram.sv =====
// ============================================================================
// chc_value_ram: symbol values by table position
// Single write port, single registered read port. The read data holds
// until the next read is issued.
// ============================================================================
`default_nettype none

module chc_value_ram #(
   parameter int MAX_SYMBOLS = chc_pkg::MAX_SYMBOLS_DEF,
   localparam int AW = $clog2(MAX_SYMBOLS)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [chc_pkg::SYM_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [chc_pkg::SYM_W-1:0] rd_data
);

   logic [chc_pkg::SYM_W-1:0] mem [MAX_SYMBOLS];
   logic [chc_pkg::SYM_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chc_code_ram.sv =====
// ============================================================================
// chc_code_ram: canonical code and length by symbol value
// Single write port, single registered read port. The read data holds
// until the next read is issued.
// ============================================================================
`default_nettype none

module chc_code_ram (
   input  wire logic                          clock,
   input  wire chc_pkg::code_wr_type          wr,
   input  wire logic                          rd_en,
   input  wire logic [chc_pkg::SYM_W-1:0]     rd_addr,
   output chc_pkg::code_entry_type            rd_data
);

   chc_pkg::code_entry_type mem [chc_pkg::SYM_NUM];
   chc_pkg::code_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chc_seq.sv =====
// ============================================================================
// chc_seq: table sequencer and bit-serial decoder
// Holds the per-length tables and code assignment state, walks code lengths
// on appends, matches decode bits against first codes and drives both
// stores. One transaction is worked on at a time.
// ============================================================================
`default_nettype none

module chc_seq #(
   parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF,
   parameter int MAX_SYMBOLS  = chc_pkg::MAX_SYMBOLS_DEF,
   localparam int AW = $clog2(MAX_SYMBOLS)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request side.
   input  wire logic                          req_valid,
   input  wire chc_pkg::req_type              req_data,
   output logic                               req_stall,
   // Result side toward the output register.
   output logic                               res_valid,
   output chc_pkg::rsp_type                   res_data,
   input  wire logic                          res_free,
   // Value store.
   output logic                               val_wr_en,
   output logic [AW-1:0]                      val_wr_addr,
   output logic [chc_pkg::SYM_W-1:0]          val_wr_data,
   output logic                               val_rd_en,
   output logic [AW-1:0]                      val_rd_addr,
   input  wire logic [chc_pkg::SYM_W-1:0]     val_rd_data,
   // Code store.
   output chc_pkg::code_wr_type               code_wr,
   output logic                               code_rd_en,
   output logic [chc_pkg::SYM_W-1:0]          code_rd_addr,
   input  wire chc_pkg::code_entry_type       code_rd_data
);

   localparam int LW = $clog2(MAX_CODE_LEN);
   localparam int CW = $clog2(MAX_CODE_LEN + 1);
   localparam int PW = $clog2(MAX_SYMBOLS + 1);
   localparam int IW = ((PW > chc_pkg::CNT_W) ? PW : chc_pkg::CNT_W) + 1;
   localparam int CODE_W = chc_pkg::CODE_W;
   localparam int LEN_W  = chc_pkg::LEN_W;

   // Sequencer state and per-length tables.
   chc_pkg::state_type state_ff, state_in;
   logic [chc_pkg::CNT_W-1:0] counts_ff     [MAX_CODE_LEN];
   logic [chc_pkg::CNT_W-1:0] counts_in     [MAX_CODE_LEN];
   logic [CODE_W-1:0]         first_code_ff [MAX_CODE_LEN];
   logic [CODE_W-1:0]         first_code_in [MAX_CODE_LEN];
   logic [PW-1:0]             first_index_ff[MAX_CODE_LEN];
   logic [PW-1:0]             first_index_in[MAX_CODE_LEN];
   logic [chc_pkg::SYM_NUM-1:0] known_ff, known_in;

   // Code assignment and decoder state.
   logic [PW-1:0]            append_pos_ff, append_pos_in;
   logic [CODE_W-1:0]        assign_code_ff, assign_code_in;
   logic [CW-1:0]            assign_len_ff, assign_len_in;
   logic [chc_pkg::CNT_W-1:0] assign_left_ff, assign_left_in;
   logic [CODE_W-1:0]        dec_bits_ff, dec_bits_in;
   logic [CW-1:0]            dec_count_ff, dec_count_in;

   // Pending transaction payload.
   logic [chc_pkg::SYM_W-1:0] pend_sym_ff, pend_sym_in;
   chc_pkg::kind_type         pend_kind_ff, pend_kind_in;
   logic [CODE_W-1:0]         pend_bits_ff, pend_bits_in;
   logic [LEN_W-1:0]          pend_len_ff, pend_len_in;

   // Decode match terms.
   logic [LW-1:0]             dec_lvl;
   logic [LW-1:0]             rd_lvl;
   logic [chc_pkg::CNT_W-1:0] count_rd;
   logic [CODE_W-1:0]         bits_new;
   logic [CW-1:0]             n_new;
   logic [CODE_W-1:0]         offset;
   logic [IW-1:0]             idx;
   logic                      dec_match;
   logic                      dec_full;
   logic [CODE_W-1:0]         code_next;

   // The decoder looks at the level of the bits gathered so far; the length
   // walk looks at the level being entered.
   assign dec_lvl  = dec_count_ff[LW-1:0];
   assign rd_lvl   = (state_ff == chc_pkg::ST_APPEND) ? assign_len_ff[LW-1:0] : dec_lvl;
   assign count_rd = counts_ff[rd_lvl];

   // Canonical first-code compare for one new bit.
   assign bits_new  = {dec_bits_ff[CODE_W-2:0], req_data.bit_req};
   assign n_new     = dec_count_ff + CW'(1);
   assign offset    = bits_new - first_code_ff[dec_lvl];
   assign idx       = IW'(first_index_ff[dec_lvl]) + IW'(offset[chc_pkg::CNT_W-1:0]);
   assign dec_match = (n_new <= assign_len_ff)
                      && (offset < CODE_W'(count_rd))
                      && (idx < IW'(append_pos_ff));
   assign dec_full  = (n_new == CW'(MAX_CODE_LEN));

   // The code doubles on entering every length after the first.
   assign code_next = (assign_len_ff != '0) ? {assign_code_ff[CODE_W-2:0], 1'b0}
                                            : assign_code_ff;

   assign req_stall = (state_ff != chc_pkg::ST_IDLE);

   // Next state, table updates and store accesses.
   always_comb begin
      state_in       = state_ff;
      counts_in      = counts_ff;
      first_code_in  = first_code_ff;
      first_index_in = first_index_ff;
      known_in       = known_ff;
      append_pos_in  = append_pos_ff;
      assign_code_in = assign_code_ff;
      assign_len_in  = assign_len_ff;
      assign_left_in = assign_left_ff;
      dec_bits_in    = dec_bits_ff;
      dec_count_in   = dec_count_ff;
      pend_sym_in    = pend_sym_ff;
      pend_kind_in   = pend_kind_ff;
      pend_bits_in   = pend_bits_ff;
      pend_len_in    = pend_len_ff;
      val_wr_en      = 1'b0;
      val_wr_addr    = append_pos_ff[AW-1:0];
      val_wr_data    = pend_sym_ff;
      val_rd_en      = 1'b0;
      val_rd_addr    = idx[AW-1:0];
      code_wr        = '0;
      code_rd_en     = 1'b0;
      code_rd_addr   = req_data.symbol;
      res_valid      = 1'b0;
      res_data       = '0;

      case (state_ff)
         chc_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  chc_pkg::FUNC_LOAD: begin
                     // Only lengths not yet entered take a new count.
                     if ((LEN_W'(req_data.length_index) < LEN_W'(MAX_CODE_LEN))
                         && (LEN_W'(req_data.length_index) >= LEN_W'(assign_len_ff))) begin
                        counts_in[req_data.length_index[LW-1:0]] = req_data.count;
                     end
                  end
                  chc_pkg::FUNC_APPEND: begin
                     // A full table drops the symbol at once.
                     if (append_pos_ff < PW'(MAX_SYMBOLS)) begin
                        pend_sym_in = req_data.symbol;
                        state_in    = chc_pkg::ST_APPEND;
                     end
                  end
                  chc_pkg::FUNC_DECODE: begin
                     if (dec_match) begin
                        val_rd_en    = 1'b1;
                        pend_kind_in = chc_pkg::KIND_SYMBOL;
                        pend_bits_in = bits_new;
                        pend_len_in  = LEN_W'(n_new);
                        dec_bits_in  = '0;
                        dec_count_in = '0;
                        state_in     = chc_pkg::ST_RESP;
                     end else if (dec_full) begin
                        pend_kind_in = chc_pkg::KIND_ERROR;
                        dec_bits_in  = '0;
                        dec_count_in = '0;
                        state_in     = chc_pkg::ST_RESP;
                     end else begin
                        dec_bits_in  = bits_new;
                        dec_count_in = n_new;
                     end
                  end
                  chc_pkg::FUNC_ENCODE: begin
                     code_rd_en   = 1'b1;
                     pend_kind_in = known_ff[req_data.symbol] ? chc_pkg::KIND_CODE
                                                              : chc_pkg::KIND_MISS;
                     state_in     = chc_pkg::ST_RESP;
                  end
                  chc_pkg::FUNC_CLEAR: begin
                     counts_in      = '{default: '0};
                     first_code_in  = '{default: '0};
                     first_index_in = '{default: '0};
                     known_in       = '0;
                     append_pos_in  = '0;
                     assign_code_in = '0;
                     assign_len_in  = '0;
                     assign_left_in = '0;
                     dec_bits_in    = '0;
                     dec_count_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         chc_pkg::ST_APPEND: begin
            if ((assign_left_ff == '0) && (assign_len_ff < CW'(MAX_CODE_LEN))) begin
               // Enter the next code length, one per cycle.
               first_code_in[assign_len_ff[LW-1:0]]  = code_next;
               first_index_in[assign_len_ff[LW-1:0]] = append_pos_ff;
               assign_code_in = code_next;
               assign_left_in = count_rd;
               assign_len_in  = assign_len_ff + CW'(1);
            end else if (assign_left_ff == '0) begin
               // No length has room left.
               state_in = chc_pkg::ST_IDLE;
            end else begin
               // Place the symbol; the first copy of a symbol owns its code.
               val_wr_en = 1'b1;
               if (!known_ff[pend_sym_ff]) begin
                  known_in[pend_sym_ff] = 1'b1;
                  code_wr.en          = 1'b1;
                  code_wr.addr        = pend_sym_ff;
                  code_wr.data.code   = assign_code_ff;
                  code_wr.data.length = LEN_W'(assign_len_ff);
               end
               assign_code_in = assign_code_ff + CODE_W'(1);
               assign_left_in = assign_left_ff - chc_pkg::CNT_W'(1);
               append_pos_in  = append_pos_ff + PW'(1);
               state_in       = chc_pkg::ST_IDLE;
            end
         end

         chc_pkg::ST_RESP: begin
            res_valid = 1'b1;
            case (pend_kind_ff)
               chc_pkg::KIND_SYMBOL: begin
                  res_data.kind        = chc_pkg::KIND_SYMBOL;
                  res_data.symbol_out  = val_rd_data;
                  res_data.code        = pend_bits_ff;
                  res_data.code_length = pend_len_ff;
               end
               chc_pkg::KIND_CODE: begin
                  res_data.kind        = chc_pkg::KIND_CODE;
                  res_data.code        = code_rd_data.code;
                  res_data.code_length = code_rd_data.length;
               end
               chc_pkg::KIND_ERROR: begin
                  res_data.kind = chc_pkg::KIND_ERROR;
               end
               default: begin
                  res_data.kind = chc_pkg::KIND_MISS;
               end
            endcase
            if (res_free) begin
               state_in = chc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = chc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and table registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= chc_pkg::ST_IDLE;
         counts_ff      <= '{default: '0};
         first_code_ff  <= '{default: '0};
         first_index_ff <= '{default: '0};
         known_ff       <= '0;
         append_pos_ff  <= '0;
         assign_code_ff <= '0;
         assign_len_ff  <= '0;
         assign_left_ff <= '0;
         dec_bits_ff    <= '0;
         dec_count_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         counts_ff      <= counts_in;
         first_code_ff  <= first_code_in;
         first_index_ff <= first_index_in;
         known_ff       <= known_in;
         append_pos_ff  <= append_pos_in;
         assign_code_ff <= assign_code_in;
         assign_len_ff  <= assign_len_in;
         assign_left_ff <= assign_left_in;
         dec_bits_ff    <= dec_bits_in;
         dec_count_ff   <= dec_count_in;
      end
   end

   // Pending transaction payload.
   always_ff @(posedge clock) begin
      pend_sym_ff  <= pend_sym_in;
      pend_kind_ff <= pend_kind_in;
      pend_bits_ff <= pend_bits_in;
      pend_len_ff  <= pend_len_in;
   end

endmodule

`default_nettype wire
